>>> src/assert_macros.svh
// Assertion macros for the checker module of the frame receiver.
// Needs signals clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, quiet while reset is high.
`define DSFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define DSFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/dsfr_pkg.sv
// Package for the DLE-stuffed frame receiver: framing bytes and result type.
// No dependencies.
`timescale 1ns / 1ps

package dsfr_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'hFF;
  localparam logic [7:0] START_BYTE = 8'hF1;
  localparam logic [7:0] END_BYTE   = 8'hF2;

  localparam logic [8:0] COUNT_MAX  = 9'd511;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [7:0] frame_code;
    logic [7:0] frame_length;
    logic [8:0] body_count;
  } dsfr_result_t;

endpackage

>>> src/dsfr_byte_if.sv
// Valid/ready channel that carries one received byte per transfer.
// No dependencies.
`timescale 1ns / 1ps

interface dsfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> src/dsfr_result_if.sv
// Valid/ready channel that carries one receiver result per transfer.
// No dependencies.
`timescale 1ns / 1ps

interface dsfr_result_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_index;
  logic [7:0] payload_byte;
  logic       frame_done;
  logic [7:0] frame_code;
  logic [7:0] frame_length;
  logic [8:0] body_count;

  modport source (
    output valid, output payload_valid, output payload_index, output payload_byte,
    output frame_done, output frame_code, output frame_length, output body_count,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_index, input payload_byte,
    input frame_done, input frame_code, input frame_length, input body_count,
    output ready
  );
endinterface

>>> src/dle_stuffed_frame_receiver.sv
// Top level of the DLE-stuffed frame receiver: handshake and result register.
// Depends on dsfr_pkg, dsfr_byte_if, dsfr_result_if and dsfr_frame_fsm.
//
//   channel  dir  modport  content per transfer
//   rx       in   sink     rx_byte, one raw byte from the link
//   res      out  source   payload and frame status for that byte
//
// Each accepted byte yields exactly one result, registered in the next cycle.
// Throughput is one byte per cycle while the sink keeps res.ready high;
// each byte takes a single pass through the framing state machine.
// Synchronous active-high reset clears the phase, count, held code and
// length, and the result valid. rx.ready stays high while the result
// register is empty or is being drained in the same cycle.
`timescale 1ns / 1ps

module dle_stuffed_frame_receiver (
  input  logic          clk,
  input  logic          rst,
  dsfr_byte_if.sink     rx,
  dsfr_result_if.source res
);
  import dsfr_pkg::*;

  dsfr_result_t step_result;
  dsfr_result_t out_reg;
  logic         out_valid;
  logic         rx_transfer;

  // Take a new byte whenever the result register is free or empties now.
  assign rx.ready    = !out_valid || res.ready;
  assign rx_transfer = rx.valid && rx.ready;

  // Advance the framing state only on an accepted byte.
  dsfr_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (rx_transfer),
    .rx_byte (rx.rx_byte),
    .result  (step_result)
  );

  // Result register: load on accept, drop valid once the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_transfer) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (rx_transfer) begin
      out_reg <= step_result;
    end
  end

  assign res.valid         = out_valid;
  assign res.payload_valid = out_reg.payload_valid;
  assign res.payload_index = out_reg.payload_index;
  assign res.payload_byte  = out_reg.payload_byte;
  assign res.frame_done    = out_reg.frame_done;
  assign res.frame_code    = out_reg.frame_code;
  assign res.frame_length  = out_reg.frame_length;
  assign res.body_count    = out_reg.body_count;

endmodule

>>> src/dsfr_frame_fsm.sv
// Framing state machine: phase, body count, held code and length.
// Depends on dsfr_pkg.
`timescale 1ns / 1ps

module dsfr_frame_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output dsfr_pkg::dsfr_result_t result
);
  import dsfr_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_ESC,
    PH_WAIT_START,
    PH_BODY,
    PH_ESCAPED
  } phase_t;

  phase_t     phase, phase_next;
  logic [8:0] count, count_next;
  logic [7:0] code, code_next;
  logic [7:0] length, length_next;

  logic add_byte;
  logic clear_count;
  logic done;
  logic in_payload;

  always_comb begin
    phase_next  = phase;
    add_byte    = 1'b0;
    clear_count = 1'b0;
    done        = 1'b0;
    case (phase)
      PH_WAIT_ESC: begin
        if (rx_byte == ESC_BYTE) phase_next = PH_WAIT_START;
      end
      PH_WAIT_START: begin
        if (rx_byte == START_BYTE) begin
          phase_next  = PH_BODY;
          clear_count = 1'b1;
        end else if (rx_byte != ESC_BYTE) begin
          phase_next = PH_WAIT_ESC;
        end
      end
      PH_BODY: begin
        if (rx_byte == ESC_BYTE) phase_next = PH_ESCAPED;
        else                     add_byte   = 1'b1;
      end
      PH_ESCAPED: begin
        if (rx_byte == ESC_BYTE) begin
          // doubled escape is a literal body byte
          add_byte   = 1'b1;
          phase_next = PH_BODY;
        end else if (rx_byte == END_BYTE) begin
          phase_next = PH_WAIT_ESC;
          done       = 1'b1;
        end else if (rx_byte == START_BYTE) begin
          phase_next  = PH_BODY;
          clear_count = 1'b1;
        end else begin
          phase_next = PH_WAIT_ESC;
        end
      end
      default: phase_next = PH_WAIT_ESC;
    endcase
  end

  always_comb begin
    code_next   = code;
    length_next = length;
    count_next  = count;
    in_payload  = 1'b0;
    if (clear_count) begin
      count_next = '0;
    end else if (add_byte) begin
      if (count == 9'd0)      code_next   = rx_byte;
      else if (count == 9'd1) length_next = rx_byte;
      else in_payload = ({1'b0, count} < ({2'b00, length} + 10'd2));
      if (count < COUNT_MAX) count_next = count + 9'd1;
    end
  end

  always_comb begin
    result.payload_valid = in_payload;
    result.payload_index = in_payload ? (count[7:0] - 8'd2) : 8'd0;
    result.payload_byte  = in_payload ? rx_byte : 8'd0;
    result.frame_done    = done;
    result.frame_code    = code_next;
    result.frame_length  = length_next;
    result.body_count    = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_WAIT_ESC;
      count  <= '0;
      code   <= '0;
      length <= '0;
    end else if (step) begin
      phase  <= phase_next;
      count  <= count_next;
      code   <= code_next;
      length <= length_next;
    end
  end

endmodule

>>> src/dsfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
// Depends on assert_macros.svh and dle_stuffed_frame_receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       payload_valid,
  input logic [7:0] payload_index,
  input logic       frame_done,
  input logic [7:0] frame_length,
  input logic [8:0] body_count
);

  `DSFR_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "result valid after reset")
  `DSFR_ASSERT(a_accept_gives_result, (in_valid && in_ready) |=> out_valid, "accepted byte lost")
  `DSFR_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(body_count) && $stable(payload_valid) && $stable(frame_done)), "stalled result changed")
  `DSFR_ASSERT(a_done_not_payload, out_valid |-> !(frame_done && payload_valid), "done and payload together")
  `DSFR_ASSERT(a_payload_bounds, (out_valid && payload_valid) |-> ((payload_index < frame_length) && (body_count == {1'b0, payload_index} + 9'd3)), "payload index out of step")

endmodule

bind dle_stuffed_frame_receiver dsfr_checker u_dsfr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (rx.valid),
  .in_ready      (rx.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .payload_valid (res.payload_valid),
  .payload_index (res.payload_index),
  .frame_done    (res.frame_done),
  .frame_length  (res.frame_length),
  .body_count    (res.body_count)
);
